[sv/three_wire_serial_master_defines.svh]
// Assertion macros used by the pin sequencer of the three-wire serial master.
`ifndef THREE_WIRE_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_SERIAL_MASTER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons in the next cycle");

`else

`define TWS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/tws_pkg.sv]
// Shared types and constants of the three-wire serial master.
`timescale 1ns / 1ps

package tws_pkg;

    // Reset value of the delay register in ticks.
    localparam logic [15:0] DelayReset = 16'd200;

    // One input tick item.
    typedef struct packed {
        logic       start_req;
        logic       op;
        logic [7:0] command;
        logic [7:0] write_data;
        logic       io_sample;
    } in_item_t;

    // One result item: pin levels and status after the tick.
    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_drive;
        logic       io_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } out_item_t;

    // Operation codes carried in the op field.
    localparam logic OpWrite = 1'b0;
    localparam logic OpRead  = 1'b1;

endpackage

[sv/tws_seq.sv]
// Pin sequencer: advances the transaction by one tick per step.
`timescale 1ns / 1ps
`include "three_wire_serial_master_defines.svh"

module tws_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  tws_pkg::in_item_t    item,
    input  logic [15:0]          delay_ticks,
    output tws_pkg::out_item_t   result
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SCK_LOW  = 4'd1,
        PH_CE_HIGH  = 4'd2,
        PH_PREP     = 4'd3,
        PH_SETIO    = 4'd4,
        PH_RISE     = 4'd5,
        PH_FALL     = 4'd6,
        PH_SAMPLE   = 4'd7,
        PH_RRISE    = 4'd8,
        PH_RFALL    = 4'd9,
        PH_GAP      = 4'd10,
        PH_END_RISE = 4'd11,
        PH_CE_OFF   = 4'd12
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [15:0] wait_reg,      wait_next;
    logic [7:0]  shift_out_reg, shift_out_next;
    logic [7:0]  shift_in_reg,  shift_in_next;
    logic [7:0]  held_reg,      held_next;
    logic        is_read_reg,   is_read_next;
    logic        ce_reg,        ce_next;
    logic        sclk_reg,      sclk_next;
    logic        drive_reg,     drive_next;
    logic        level_reg,     level_next;
    logic [7:0]  latch_reg,     latch_next;
    logic        done_next;
    logic [3:0]  nb;

    // Next-state logic for one tick.
    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        wait_next      = wait_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        held_next      = held_reg;
        is_read_next   = is_read_reg;
        ce_next        = ce_reg;
        sclk_next      = sclk_reg;
        drive_next     = drive_reg;
        level_next     = level_reg;
        latch_next     = latch_reg;
        done_next      = 1'b0;
        nb             = bit_index_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            // A start request latches the whole transaction.
            if (item.start_req)
            begin
                is_read_next   = (item.op == tws_pkg::OpRead);
                shift_out_next = item.command;
                held_next      = item.write_data;
                bit_index_next = 4'd0;
                ce_next        = 1'b0;
                phase_next     = PH_SCK_LOW;
                wait_next      = delay_ticks;
            end
        end
        else if (wait_reg != 16'd0)
        begin
            wait_next = wait_reg - 16'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_SCK_LOW:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_CE_HIGH;
                end
                PH_CE_HIGH:
                begin
                    ce_next    = 1'b1;
                    phase_next = PH_PREP;
                end
                PH_PREP:
                begin
                    drive_next = 1'b1;
                    sclk_next  = 1'b0;
                    phase_next = PH_SETIO;
                end
                PH_SETIO:
                begin
                    level_next = shift_out_reg[0];
                    phase_next = PH_RISE;
                end
                PH_RISE:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_FALL;
                end
                PH_FALL:
                begin
                    sclk_next      = 1'b0;
                    shift_out_next = shift_out_reg >> 1;
                    bit_index_next = nb;
                    // After the command byte, either turn the bus or load the data byte; after the data byte, end.
                    if (nb == 4'd0)
                    begin
                        phase_next = PH_END_RISE;
                    end
                    else if (nb == 4'd8)
                    begin
                        if (is_read_reg)
                        begin
                            drive_next    = 1'b0;
                            shift_in_next = 8'd0;
                            phase_next    = PH_SAMPLE;
                        end
                        else
                        begin
                            shift_out_next = held_reg;
                            drive_next     = 1'b1;
                            phase_next     = PH_SETIO;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SETIO;
                    end
                end
                PH_SAMPLE:
                begin
                    shift_in_next = {item.io_sample, shift_in_reg[7:1]};
                    phase_next    = PH_RRISE;
                end
                PH_RRISE:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_RFALL;
                end
                PH_RFALL:
                begin
                    sclk_next      = 1'b0;
                    bit_index_next = nb;
                    phase_next     = (nb == 4'd0) ? PH_GAP : PH_SAMPLE;
                end
                PH_GAP:
                begin
                    phase_next = PH_END_RISE;
                end
                PH_END_RISE:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_CE_OFF;
                end
                default:
                begin
                    // Final CE low ends the transaction and latches a read byte; unused codes end here too.
                    ce_next = 1'b0;
                    if (is_read_reg)
                    begin
                        latch_next = shift_in_reg;
                    end
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
            wait_next = (phase_next == PH_IDLE) ? 16'd0 : delay_ticks;
        end
    end

    // State and pin registers, updated once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_index_reg <= 4'd0;
            wait_reg      <= 16'd0;
            shift_out_reg <= 8'd0;
            shift_in_reg  <= 8'd0;
            held_reg      <= 8'd0;
            is_read_reg   <= 1'b0;
            ce_reg        <= 1'b0;
            sclk_reg      <= 1'b1;
            drive_reg     <= 1'b1;
            level_reg     <= 1'b1;
            latch_reg     <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            wait_reg      <= wait_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
            held_reg      <= held_next;
            is_read_reg   <= is_read_next;
            ce_reg        <= ce_next;
            sclk_reg      <= sclk_next;
            drive_reg     <= drive_next;
            level_reg     <= level_next;
            latch_reg     <= latch_next;
        end
    end

    // The result shows the levels after this tick's action.
    always_comb
    begin
        result.chip_enable  = ce_next;
        result.serial_clock = sclk_next;
        result.io_drive     = drive_next;
        result.io_level     = level_next;
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done_next;
        result.read_data    = latch_next;
    end

    // A completed transaction leaves the sequencer idle.
    `TWS_ASSERT_NEXT(a_done_to_idle, clk, rst_n, step && done_next, phase_reg == PH_IDLE)
    // Pins hold steady while a delay phase counts down.
    `TWS_ASSERT_NEXT(a_wait_pins_hold, clk, rst_n,
        step && (phase_reg != PH_IDLE) && (wait_reg != 16'd0),
        $stable(ce_reg) && $stable(sclk_reg) && $stable(drive_reg) && $stable(level_reg))
    // CE stays asserted while bits move.
    `TWS_ASSERT_IMPL(a_ce_during_bits, clk, rst_n,
        phase_reg == PH_SETIO || phase_reg == PH_RISE || phase_reg == PH_SAMPLE
            || phase_reg == PH_RRISE || phase_reg == PH_RFALL, ce_reg)
    // IO is released for the whole read byte.
    `TWS_ASSERT_IMPL(a_io_released_on_read, clk, rst_n,
        phase_reg == PH_SAMPLE || phase_reg == PH_RRISE || phase_reg == PH_RFALL
            || phase_reg == PH_GAP, !drive_reg)

endmodule

[sv/three_wire_serial_master.sv]
// A tick's result passes from the input register through the sequencer into the result register.
// Throughput: one tick per clock cycle; the input register and result register
// both advance whenever the result register is empty or being taken.
// Reset: asynchronous, active low; sequencer idle, CE low, SCLK high, IO driven
// high, delay register at 200, read byte zero, no items held.
`timescale 1ns / 1ps

module three_wire_serial_master (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tws_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tws_pkg::out_item_t   out_item,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data
);

    logic                 in_valid_reg;
    tws_pkg::in_item_t    in_item_reg;
    logic                 out_valid_reg;
    tws_pkg::out_item_t   out_item_reg;
    logic [15:0]          delay_reg;
    logic                 step;
    tws_pkg::out_item_t   result;

    // The held tick advances when the result register can take its result.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // Delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= tws_pkg::DelayReset;
        end
        else if (cfg_we)
        begin
            delay_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    // Sequencer.
    tws_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (in_item_reg),
        .delay_ticks (delay_reg),
        .result      (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
